// ===== src/aaa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaa_pkg
// Shared widths, codes, tracker state type and saturating add for the
// altitude ascent accumulator.
// ----------------------------------------------------------------------------
package aaa_pkg;

	localparam int ALT_W   = 16;          // altitude, metres, signed
	localparam int TOTAL_W = 24;          // ascent total, unsigned
	localparam int THR_W   = 8;           // turn threshold
	localparam int DIFF_W  = ALT_W + 1;   // difference of two altitudes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// feet = floor(|rel| * 328 / 100), done as |rel| * ceil(328 * 2^24 / 100) >> 24.
	// Error stays below 1/25 over the whole altitude range, so the floor is exact.
	localparam int FEET_NUM     = 328;
	localparam int FEET_DEN     = 100;
	localparam int FEET_SHIFT   = 24;
	localparam int FEET_RECIP_W = 26;
	localparam logic [FEET_RECIP_W-1:0] FEET_RECIP = FEET_RECIP_W'(
		((longint'(FEET_NUM) << FEET_SHIFT) + longint'(FEET_DEN) - 1) / longint'(FEET_DEN));
	localparam int PROD_W = DIFF_W + FEET_RECIP_W;
	localparam int REL_W  = PROD_W - FEET_SHIFT;   // 19-bit relative altitude

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [THR_W-1:0]   THR_RESET = THR_W'(5);

	localparam logic KIND_START  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLED        = 2'd0,
		CFG_TURN_THRESHOLD = 2'd1,
		CFG_REPORT_IN_FEET = 2'd2
	} aaa_cfg_idx_t;

	typedef logic signed [ALT_W-1:0] alt_t;

	typedef struct packed {
		alt_t               start_point;
		alt_t               last_turn;
		alt_t               prev_alt;
		alt_t               peak;
		logic [TOTAL_W-1:0] committed;
		logic               up;
	} aaa_state_t;

	// a + b, clamped at TOTAL_MAX
	function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
			input logic [DIFF_W-1:0] b);
		logic [TOTAL_W:0] sum;
		sum = {1'b0, a} + (TOTAL_W+1)'(b);
		if (sum >= {1'b0, TOTAL_MAX})
			return TOTAL_MAX;
		return sum[TOTAL_W-1:0];
	endfunction

endpackage

// ===== src/aaa_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaa_step
// Next tracker state and running ascent total for one altitude word.
// ----------------------------------------------------------------------------
module aaa_step import aaa_pkg::*; (
	input  aaa_state_t         cur,
	input  logic               kind,
	input  alt_t               altitude,
	input  logic               enabled,
	input  logic [THR_W-1:0]   turn_threshold,
	output aaa_state_t         nxt,
	output logic [TOTAL_W-1:0] total
);

	logic signed [DIFF_W-1:0] alt_x;
	logic signed [DIFF_W-1:0] prev_x;
	logic signed [DIFF_W-1:0] drop;
	logic signed [DIFF_W-1:0] rise;
	logic signed [DIFF_W-1:0] climb;
	logic signed [DIFF_W-1:0] gain;
	logic signed [DIFF_W-1:0] thr_x;

	assign alt_x  = DIFF_W'(altitude);
	assign prev_x = DIFF_W'(cur.prev_alt);
	assign drop   = prev_x - alt_x;
	assign rise   = alt_x - prev_x;
	assign climb  = prev_x - DIFF_W'(cur.last_turn);
	assign thr_x  = $signed({{(DIFF_W-THR_W){1'b0}}, turn_threshold});

	always_comb begin
		nxt = cur;
		if (kind == KIND_START) begin
			nxt.start_point = altitude;
			nxt.last_turn   = altitude;
			nxt.prev_alt    = altitude;
			nxt.peak        = altitude;
			nxt.committed   = '0;
			nxt.up          = 1'b1;
		end else if (enabled) begin
			if (altitude > cur.peak)
				nxt.peak = altitude;
			if (cur.up) begin
				if (altitude >= cur.prev_alt) begin
					nxt.prev_alt = altitude;
				end else if (drop >= thr_x) begin
					// climb over: bank it, pivot stays at prev_alt
					if (climb > 0)
						nxt.committed = sat_add(cur.committed, climb);
					nxt.last_turn = cur.prev_alt;
					nxt.up        = 1'b0;
				end
			end else begin
				if (altitude <= cur.prev_alt) begin
					nxt.prev_alt = altitude;
				end else if (rise >= thr_x) begin
					nxt.last_turn = cur.prev_alt;
					nxt.up        = 1'b1;
				end
			end
		end
	end

	assign gain = alt_x - DIFF_W'(nxt.last_turn);

	// climb in progress only counts while heading up and above the pivot
	always_comb begin
		total = nxt.committed;
		if (nxt.up && (gain > 0))
			total = sat_add(nxt.committed, gain);
	end

endmodule

// ===== src/altitude_ascent_accumulator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altitude_ascent_accumulator_unit
// Total-ascent accumulator with turn hysteresis over altitude samples.
// ----------------------------------------------------------------------------
//  channel | signals                                    | dir | word
//  --------+--------------------------------------------+-----+------------------
//  in      | in_valid, in_ready, kind, altitude          | in  | one sample/start
//  out     | out_valid, out_ready, relative_altitude,    | out | one result/word
//          | ascent_total, peak_altitude, going_up       |     |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data   | in  | one register write
//
//  One word in per clock, sustained while out_ready is high. An accepted word
//  passes the input register, then tracker update plus feet multiply into
//  stage 2, then the output register, where out_valid rises for it.
//  The tracker state updates when a word leaves the input register, so the next
//  word sees it on reaching the input register, with no bubble.
//  out_ready low stalls the pipe stage by stage; up to three words are held.
//  arst_n clears all valid bits, config to reset values and the tracker state.
//  cfg_ready is always high; writes are expected only while the pipe is empty.
// ----------------------------------------------------------------------------
module altitude_ascent_accumulator_unit import aaa_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       kind,
	input  logic signed [ALT_W-1:0]    altitude,

	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [REL_W-1:0]    relative_altitude,
	output logic [TOTAL_W-1:0]         ascent_total,
	output logic signed [ALT_W-1:0]    peak_altitude,
	output logic                       going_up,

	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	// config registers
	logic              enabled_q;
	logic [THR_W-1:0]  thr_q;
	logic              feet_q;

	// tracker state
	aaa_state_t        state_q;
	aaa_state_t        state_nxt;
	logic [TOTAL_W-1:0] total_nxt;

	// stage 1: input register
	logic              v_s1;
	logic              kind_s1;
	alt_t              alt_s1;

	// stage 2: tracker results and feet product
	logic              v_s2;
	logic signed [DIFF_W-1:0] rel_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [TOTAL_W-1:0] total_s2;
	alt_t              peak_s2;
	logic              up_s2;

	// flow control
	logic              out_free;
	logic              s2_free;
	logic              adv_s1;
	logic              adv_s2;

	// stage 1 combinational
	logic signed [DIFF_W-1:0] rel_s1;
	logic [DIFF_W-1:0] mag_s1;
	logic [PROD_W-1:0] prod_s1;

	// output formatting
	logic [REL_W-1:0]  feet_mag;
	logic [REL_W-1:0]  rel_fmt;

	assign out_free = !out_valid || out_ready;
	assign s2_free  = !v_s2 || out_free;
	assign adv_s2   = v_s2 && out_free;
	assign adv_s1   = v_s1 && s2_free;
	assign in_ready = !v_s1 || s2_free;
	assign cfg_ready = 1'b1;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			thr_q     <= THR_RESET;
			feet_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ENABLED:        enabled_q <= cfg_data[0];
				CFG_TURN_THRESHOLD: thr_q     <= cfg_data[THR_W-1:0];
				CFG_REPORT_IN_FEET: feet_q    <= cfg_data[0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// ---------------- stage 1: input register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			alt_s1  <= altitude;
		end
	end

	// ---------------- tracker update ----------------
	aaa_step u_step (
		.cur            (state_q),
		.kind           (kind_s1),
		.altitude       (alt_s1),
		.enabled        (enabled_q),
		.turn_threshold (thr_q),
		.nxt            (state_nxt),
		.total          (total_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.start_point <= '0;
			state_q.last_turn   <= '0;
			state_q.prev_alt    <= '0;
			state_q.peak        <= '0;
			state_q.committed   <= '0;
			state_q.up          <= 1'b1;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// relative altitude against the (possibly new) start point; the feet
	// product works on the magnitude so the divide truncates toward zero
	assign rel_s1  = DIFF_W'(alt_s1) - DIFF_W'(state_nxt.start_point);
	assign mag_s1  = rel_s1[DIFF_W-1] ? DIFF_W'(-rel_s1) : DIFF_W'(rel_s1);
	assign prod_s1 = PROD_W'(mag_s1) * PROD_W'(FEET_RECIP);

	// ---------------- stage 2 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rel_s2   <= rel_s1;
			prod_s2  <= prod_s1;
			total_s2 <= total_nxt;
			peak_s2  <= state_nxt.peak;
			up_s2    <= state_nxt.up;
		end
	end

	// ---------------- output register ----------------
	assign feet_mag = prod_s2[PROD_W-1:FEET_SHIFT];

	always_comb begin
		if (feet_q)
			rel_fmt = rel_s2[DIFF_W-1] ? REL_W'(-feet_mag) : feet_mag;
		else
			rel_fmt = REL_W'(rel_s2);   // sign-extends the metre value
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			relative_altitude <= $signed(rel_fmt);
			ascent_total      <= total_s2;
			peak_altitude     <= peak_s2;
			going_up          <= up_s2;
		end
	end

endmodule

// ===== src/aaa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaa_checker
// Port-level checks for the altitude ascent accumulator, bound to the top.
// ----------------------------------------------------------------------------
module aaa_checker import aaa_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    kind,
	input logic signed [ALT_W-1:0] altitude,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [REL_W-1:0] relative_altitude,
	input logic [TOTAL_W-1:0]      ascent_total,
	input logic signed [ALT_W-1:0] peak_altitude,
	input logic                    going_up,
	input logic                    cfg_valid,
	input logic                    cfg_ready,
	input logic [CFG_IDX_W-1:0]    cfg_index,
	input logic [CFG_DATA_W-1:0]   cfg_data
);

	localparam logic signed [REL_W-1:0] REL_LIMIT = REL_W'(214955);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(relative_altitude)
			&& $stable(ascent_total) && $stable(peak_altitude) && $stable(going_up))
		else $error("result word changed while stalled");

	// a free sink never throttles the source
	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("in_ready low while out_ready high");

	// accepted word reaches the output register when the sink stays free
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result word late");

	// feet scaling stays inside the field range
	a_rel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (relative_altitude <= REL_LIMIT) && (relative_altitude >= -REL_LIMIT))
		else $error("relative altitude out of range");

endmodule

bind altitude_ascent_accumulator_unit aaa_checker u_aaa_checker (.*);
